FILE: sv/cwi_pkg.sv
// shared types and constants for the cyclic waypoint interpolator
package cwi_pkg;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // speed after reset, 1.0 in Q8.8
  localparam logic [15:0] SPEED_RESET = 16'd256;

  // one waypoint in the store: z, y, x
  localparam int POINT_W = 48;

  // input word
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic [15:0]        delta_time;
  } in_item_t;

  // result word
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               is_playing;
    logic [9:0]         current_segment;
    logic [10:0]        stored_count;
    logic               store_full;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic apply_op;
    logic mul2;
    logic sum;
    logic div_step;
    logic div_last;
    logic rd_b;
    logic lerp_mul;
    logic lerp_add;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_go;
    logic interp_go;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/cwi_ram.sv
// generic simple dual-port ram with registered read
module cwi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/cwi_ctrl.sv
// sequencing state machine for the waypoint interpolator
module cwi_ctrl #(
  parameter int MAX_POINTS = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cwi_pkg::sts_t sts,
  output cwi_pkg::cmd_t cmd
);
  import cwi_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = CNT_W + 10;
  localparam int DCNT_W = $clog2(SUM_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_RDA   = 4'd6;
  localparam logic [3:0] S_RDB   = 4'd7;
  localparam logic [3:0] S_LMUL  = 4'd8;
  localparam logic [3:0] S_LADD  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

  logic [3:0]        state_r, state_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.apply_op = 1'b1;
        state_nxt    = sts.tick_go ? S_MUL2 : S_CHECK;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          cmd.div_last = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.interp_go ? S_RDA : S_DONE;
      end
      S_RDA: begin
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_LMUL;
      end
      S_LMUL: begin
        cmd.lerp_mul = 1'b1;
        state_nxt    = S_LADD;
      end
      S_LADD: begin
        cmd.lerp_add = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: sv/cwi_datapath.sv
// waypoint store, progress arithmetic, remainder unit and interpolation lanes
module cwi_datapath #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cwi_pkg::in_item_t  in_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cwi_pkg::out_item_t out_data,
  input  cwi_pkg::cmd_t      cmd,
  output cwi_pkg::sts_t      sts
);
  import cwi_pkg::*;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int PROD_W  = 32 + CNT_W;
  localparam int INC_W   = PROD_W - 8;
  localparam int TOTAL_W = INC_W + 1;
  localparam int WHOLE_W = TOTAL_W - 16;
  localparam int SUM_W   = WHOLE_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  // architectural state
  logic [15:0]      speed_r;
  logic [CNT_W-1:0] count_r;
  logic             playing_r;
  logic [15:0]      progress_r;
  logic [IDX_W-1:0] index_r;
  logic             full_r;

  // work registers
  in_item_t          item_r;
  logic [31:0]       prod1_r;
  logic [PROD_W-1:0] prod2_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  rem_r;
  logic signed [15:0] a_r    [3];
  logic signed [33:0] lprod_r [3];
  logic signed [15:0] pos_r  [3];
  out_item_t         out_r;
  logic              out_valid_r;

  // combinational helpers
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [POINT_W-1:0]     ram_rdata;
  logic [IDX_W-1:0]       next_idx;
  logic [CNT_W-1:0]       idx_inc;
  logic [TOTAL_W-1:0]     total;
  logic [SUM_W-1:0]       sum_val;
  logic [CNT_W:0]         rem_shift;
  logic [CNT_W:0]         rem_cmp;
  logic [CNT_W-1:0]       rem_nxt;
  logic signed [15:0]     base   [3];
  logic signed [15:0]     b_val  [3];
  logic signed [16:0]     diff   [3];
  logic signed [16:0]     t_s;
  logic signed [33:0]     lprod  [3];
  logic signed [33:0]     rnd    [3];
  logic signed [15:0]     pos    [3];
  logic [IDX_W+9:0]       seg_ext;
  logic [CNT_W+10:0]      cnt_ext;
  logic                   has_two;

  assign cfg_ready = 1'b1;
  assign has_two   = (count_r >= CNT_TWO);

  // status toward the controller
  assign sts.tick_go   = (item_r.operation == OP_TICK) && playing_r && has_two;
  assign sts.interp_go = playing_r && has_two;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // waypoint store
  assign ram_we = cmd.apply_op && (item_r.operation == OP_ADD) && (count_r < CNT_MAX);

  assign idx_inc   = CNT_W'(index_r) + 1'b1;
  assign next_idx  = (idx_inc == count_r) ? '0 : idx_inc[IDX_W-1:0];
  assign ram_raddr = cmd.rd_b ? next_idx : index_r;

  cwi_ram #(
    .WIDTH(POINT_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[IDX_W-1:0]),
    .wdata({item_r.vec_z, item_r.vec_y, item_r.vec_x}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // progress accumulation and segment advance
  assign total   = TOTAL_W'(progress_r) + TOTAL_W'(prod2_r[PROD_W-1:8]);
  assign sum_val = SUM_W'(index_r) + SUM_W'(total[TOTAL_W-1:16]);

  // one restoring remainder step per cycle
  assign rem_shift = {rem_r, sum_r[SUM_W-1]};
  assign rem_cmp   = {1'b0, count_r};
  assign rem_nxt   = (rem_shift >= rem_cmp) ? CNT_W'(rem_shift - rem_cmp)
                                            : CNT_W'(rem_shift);

  // interpolation lanes
  assign base[0]  = item_r.vec_x;
  assign base[1]  = item_r.vec_y;
  assign base[2]  = item_r.vec_z;
  assign b_val[0] = ram_rdata[15:0];
  assign b_val[1] = ram_rdata[31:16];
  assign b_val[2] = ram_rdata[47:32];
  assign t_s      = $signed({1'b0, progress_r});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = $signed({b_val[k][15], b_val[k]}) - $signed({a_r[k][15], a_r[k]});
      lprod[k] = diff[k] * t_s;
      rnd[k]   = lprod_r[k] + 34'sd32768;
      pos[k]   = a_r[k] + $signed(rnd[k][31:16]);
    end
  end

  // fixed-width status fields
  assign seg_ext = {10'b0, index_r};
  assign cnt_ext = {11'b0, count_r};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= SPEED_RESET;
      count_r     <= '0;
      playing_r   <= 1'b0;
      progress_r  <= '0;
      index_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        speed_r <= cfg_data;
      end
      if (cmd.apply_op) begin
        case (item_r.operation)
          OP_ADD: begin
            if (count_r < CNT_MAX) begin
              count_r <= count_r + 1'b1;
            end
          end
          OP_CLEAR: begin
            count_r    <= '0;
            playing_r  <= 1'b0;
            progress_r <= '0;
            index_r    <= '0;
          end
          OP_TOGGLE: begin
            if (has_two) begin
              playing_r <= !playing_r;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.sum) begin
        progress_r <= total[15:0];
      end
      if (cmd.div_last) begin
        index_r <= rem_nxt[IDX_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.apply_op) begin
      full_r  <= (item_r.operation == OP_ADD) && (count_r == CNT_MAX);
      prod1_r <= 32'(speed_r) * 32'(item_r.delta_time);
    end
    if (cmd.mul2) begin
      prod2_r <= PROD_W'(prod1_r) * PROD_W'(count_r);
    end
    if (cmd.sum) begin
      sum_r <= sum_val;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      sum_r <= sum_r << 1;
      rem_r <= rem_nxt;
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd.rd_b) begin
        a_r[k] <= b_val[k];
      end
      if (cmd.lerp_mul) begin
        lprod_r[k] <= lprod[k];
      end
      if (cmd.lerp_add) begin
        pos_r[k] <= pos[k];
      end
    end
    if (cmd.out_load) begin
      out_r.pos_x           <= sts.interp_go ? pos_r[0] : base[0];
      out_r.pos_y           <= sts.interp_go ? pos_r[1] : base[1];
      out_r.pos_z           <= sts.interp_go ? pos_r[2] : base[2];
      out_r.is_playing      <= playing_r;
      out_r.current_segment <= seg_ext[9:0];
      out_r.stored_count    <= cnt_ext[10:0];
      out_r.store_full      <= full_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/cyclic_waypoint_interpolator_unit.sv
// top level of the cyclic waypoint interpolator
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+----------------------------
//   in_     | input     | in_valid/in_stall  | in_item_t: op, vector, dt
//   out_    | output    | out_valid/out_stall| out_item_t: position, status
//   cfg_    | input     | cfg_valid/cfg_ready| speed, Q8.8
//
// one item at a time; from acceptance, a stopped block loads the result
// directly, a playing one first reads the store and interpolates, and a tick
// while playing first runs a bit-serial remainder over W = clog2(MAX_POINTS +
// 1) + 10 bits (21 at 1024 points) that wraps the segment index; two store
// reads and a multiply then add set the interpolation part
// a new word is taken while the previous result waits in the output register
// rst_n is synchronous; the store holds no reset and needs no clearing pass
module cyclic_waypoint_interpolator_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cwi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cwi_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import cwi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  cwi_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // datapath
  cwi_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

FILE: sv/cwi_checker.sv
// port-level checks for the waypoint interpolator and their binding
module cwi_checker #(
  parameter int MAX_POINTS = 1024
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cwi_pkg::out_item_t out_data
);
  import cwi_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a taken word makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // playback needs two points and a segment inside the store
  a_play_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_playing |->
      (MAX_POINTS > 1024) ||
      (out_data.stored_count >= 11'd2 &&
       11'(out_data.current_segment) < out_data.stored_count))
    else $error("playing with an invalid segment or count");

  // a rejected add only happens with a full store
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.store_full |->
      (MAX_POINTS > 1024) || (out_data.stored_count == 11'(MAX_POINTS)))
    else $error("full flag without a full store");

endmodule

bind cyclic_waypoint_interpolator_unit cwi_checker #(
  .MAX_POINTS(MAX_POINTS)
) u_cwi_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
